// ===== hw/rtl/rpl_pkg.sv =====
package rpl_pkg;

	localparam int TABLE_DEPTH = 16;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_LOOKUP = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_MISS = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] route_net;
		logic [31:0] route_mask;
		logic [31:0] route_gateway;
		logic [7:0]  route_iface;
		logic [31:0] lookup_addr;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] hit_net;
		logic [31:0] hit_mask;
		logic [31:0] hit_gateway;
		logic [7:0]  hit_iface;
	} rsp_t;

	typedef struct packed {
		logic [31:0] net;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [7:0]  iface;
	} route_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOOK_RD,
		ST_LOOK_CHK,
		ST_INS_RD,
		ST_INS_CHK
	} state_t;

	// true when stored entry a stays ahead of new entry b
	function automatic logic keeps_place(route_t a, route_t b);
		logic r;
		if (a.net != b.net) begin
			r = (a.net > b.net);
		end else begin
			r = (a.mask >= b.mask);
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/ipv4_route_prefix_lookup.sv =====
// channel   ports               handshake
// request   req (req_t)         accepted at clk rise with start high and busy low
// result    rsp (rsp_t)         valid for the one cycle that done is high
//
// Lookup scans entries from 0 until a match, or misses once all routes have been read.
// Insert reads entries walking down from the end, shifting each up one place, until
// one keeps its place or the route lands at entry 0. Full table, clear, unused modes: no table access.
// done rises in the first cycle that busy is low; a new start is taken in that cycle.
// Each entry step is a table read, then a compare (and on insert a write) in the cycle after.
// Reset clears count and control; table contents are not cleared. done cannot be stalled.
module ipv4_route_prefix_lookup #(
	parameter int TABLE_DEPTH = rpl_pkg::TABLE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  rpl_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output rpl_pkg::rsp_t rsp
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	rpl_pkg::state_t state_q, state_d;
	rpl_pkg::req_t   cmd_q;
	logic [CW-1:0]   count_q, count_d;
	logic [AW-1:0]   idx_q, idx_d;
	logic [CW-1:0]   scan_q, scan_d;
	logic            done_q;
	rpl_pkg::rsp_t   rsp_q;

	logic            rd_en, wr_en;
	logic [AW-1:0]   rd_addr, wr_addr;
	rpl_pkg::route_t wr_data, rd_data, ent_new;
	logic            fin;
	rpl_pkg::rsp_t   fin_rsp;
	logic            hit, keep;

	assign ent_new.net     = cmd_q.route_net;
	assign ent_new.mask    = cmd_q.route_mask;
	assign ent_new.gateway = cmd_q.route_gateway;
	assign ent_new.iface   = cmd_q.route_iface;

	assign hit  = ((cmd_q.lookup_addr & rd_data.mask) == rd_data.net);
	assign keep = rpl_pkg::keeps_place(rd_data, ent_new);

	rpl_table_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rpl_pkg::ST_IDLE: begin
				if (start) begin
					state_d = rpl_pkg::ST_EXEC;
				end
			end
			rpl_pkg::ST_EXEC: begin
				unique case (cmd_q.mode)
					rpl_pkg::MODE_INSERT: begin
						state_d = (count_q >= DEPTH_C) ? rpl_pkg::ST_IDLE
							: rpl_pkg::ST_INS_RD;
					end
					rpl_pkg::MODE_LOOKUP: state_d = rpl_pkg::ST_LOOK_RD;
					default:              state_d = rpl_pkg::ST_IDLE;
				endcase
			end
			rpl_pkg::ST_LOOK_RD: begin
				state_d = (scan_q >= count_q) ? rpl_pkg::ST_IDLE : rpl_pkg::ST_LOOK_CHK;
			end
			rpl_pkg::ST_LOOK_CHK: begin
				state_d = hit ? rpl_pkg::ST_IDLE : rpl_pkg::ST_LOOK_RD;
			end
			rpl_pkg::ST_INS_RD: begin
				state_d = (idx_q == '0) ? rpl_pkg::ST_IDLE : rpl_pkg::ST_INS_CHK;
			end
			rpl_pkg::ST_INS_CHK: begin
				state_d = keep ? rpl_pkg::ST_IDLE : rpl_pkg::ST_INS_RD;
			end
			default: state_d = rpl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q - AW'(1);
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = ent_new;
		fin     = 1'b0;
		fin_rsp = '0;
		count_d = count_q;
		idx_d   = idx_q;
		scan_d  = scan_q;
		unique case (state_q)
			rpl_pkg::ST_IDLE: begin
			end
			rpl_pkg::ST_EXEC: begin
				idx_d  = count_q[AW-1:0];
				scan_d = '0;
				unique case (cmd_q.mode)
					rpl_pkg::MODE_INSERT: begin
						if (count_q >= DEPTH_C) begin
							fin            = 1'b1;
							fin_rsp.status = rpl_pkg::STATUS_FULL;
						end
					end
					rpl_pkg::MODE_LOOKUP: begin
					end
					rpl_pkg::MODE_CLEAR: begin
						count_d = '0;
						fin     = 1'b1;
					end
					default: fin = 1'b1;
				endcase
			end
			rpl_pkg::ST_LOOK_RD: begin
				rd_addr = scan_q[AW-1:0];
				if (scan_q >= count_q) begin
					fin            = 1'b1;
					fin_rsp.status = rpl_pkg::STATUS_MISS;
				end else begin
					rd_en = 1'b1;
				end
			end
			rpl_pkg::ST_LOOK_CHK: begin
				if (hit) begin
					fin                 = 1'b1;
					fin_rsp.status      = rpl_pkg::STATUS_OK;
					fin_rsp.hit_net     = rd_data.net;
					fin_rsp.hit_mask    = rd_data.mask;
					fin_rsp.hit_gateway = rd_data.gateway;
					fin_rsp.hit_iface   = rd_data.iface;
				end else begin
					scan_d = scan_q + CW'(1);
				end
			end
			rpl_pkg::ST_INS_RD: begin
				if (idx_q == '0) begin
					wr_en   = 1'b1;
					fin     = 1'b1;
					count_d = count_q + CW'(1);
				end else begin
					rd_en = 1'b1;
				end
			end
			rpl_pkg::ST_INS_CHK: begin
				wr_en = 1'b1;
				if (keep) begin
					fin     = 1'b1;
					count_d = count_q + CW'(1);
				end else begin
					wr_data = rd_data;
					idx_d   = idx_q - AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpl_pkg::ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (start && (state_q == rpl_pkg::ST_IDLE)) begin
			cmd_q <= req;
		end
		idx_q  <= idx_d;
		scan_q <= scan_d;
		if (fin) begin
			rsp_q <= fin_rsp;
		end
	end

	assign busy = (state_q != rpl_pkg::ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== hw/rtl/rpl_table_mem.sv =====
module rpl_table_mem #(
	parameter int DEPTH = rpl_pkg::TABLE_DEPTH,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  rpl_pkg::route_t wr_data,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output rpl_pkg::route_t rd_data
);

	rpl_pkg::route_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/rpl_checker.sv =====
module rpl_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input rpl_pkg::rsp_t rsp
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted transaction");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_nohit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status != rpl_pkg::STATUS_OK)) |->
		((rsp.hit_net == '0) && (rsp.hit_mask == '0) &&
		 (rsp.hit_gateway == '0) && (rsp.hit_iface == '0)))
		else $error("hit fields nonzero without a match");

endmodule

bind ipv4_route_prefix_lookup rpl_checker u_rpl_checker (.*);

// ===== verif/ipv4_route_prefix_lookup_test.sv =====
`timescale 1ns / 100ps

module ipv4_route_prefix_lookup_test;

	localparam logic [1:0] MODE_NOP = 2'd3;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_ITEMS = 1725;
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_REPORTS = 200;

	class lpm_scoreboard;
		rpl_pkg::route_t routes[rpl_pkg::TABLE_DEPTH];
		int unsigned n_routes;
		rpl_pkg::rsp_t pending_replies[$];
		int unsigned errors;

		function new();
			n_routes = 0;
			errors = 0;
		endfunction

		function rpl_pkg::rsp_t forward_decision(rpl_pkg::req_t r);
			rpl_pkg::rsp_t o;
			rpl_pkg::route_t e;
			int unsigned pos;
			o = '0;
			o.status = rpl_pkg::STATUS_OK;
			case (r.mode)
				rpl_pkg::MODE_INSERT: begin
					e.net = r.route_net;
					e.mask = r.route_mask;
					e.gateway = r.route_gateway;
					e.iface = r.route_iface;
					if (n_routes >= rpl_pkg::TABLE_DEPTH) begin
						o.status = rpl_pkg::STATUS_FULL;
					end else begin
						pos = 0;
						// sorted by net, then mask, both descending; ties stay in arrival order
						while (pos < n_routes && (routes[pos].net > e.net ||
							(routes[pos].net == e.net && routes[pos].mask >= e.mask)))
							pos++;
						for (int i = n_routes; i > pos; i--)
							routes[i] = routes[i - 1];
						routes[pos] = e;
						n_routes++;
					end
				end
				rpl_pkg::MODE_LOOKUP: begin
					o.status = rpl_pkg::STATUS_MISS;
					for (int i = 0; i < n_routes; i++) begin
						if ((r.lookup_addr & routes[i].mask) == routes[i].net) begin
							o.status = rpl_pkg::STATUS_OK;
							o.hit_net = routes[i].net;
							o.hit_mask = routes[i].mask;
							o.hit_gateway = routes[i].gateway;
							o.hit_iface = routes[i].iface;
							break;
						end
					end
				end
				rpl_pkg::MODE_CLEAR: begin
					n_routes = 0;
				end
				default: begin
				end
			endcase
			return o;
		endfunction

		function void note_request(rpl_pkg::req_t r);
			pending_replies.push_back(forward_decision(r));
		endfunction

		function void mismatch(string what, logic [31:0] exp, logic [31:0] act);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp, act);
		endfunction

		function void check_reply(rpl_pkg::rsp_t a);
			rpl_pkg::rsp_t x;
			if (pending_replies.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected transaction, expected none, actual %h",
						$time, a);
			end else begin
				x = pending_replies.pop_front();
				if (a.status !== x.status)
					mismatch("status", 32'(x.status), 32'(a.status));
				if (a.hit_net !== x.hit_net)
					mismatch("hit_net", x.hit_net, a.hit_net);
				if (a.hit_mask !== x.hit_mask)
					mismatch("hit_mask", x.hit_mask, a.hit_mask);
				if (a.hit_gateway !== x.hit_gateway)
					mismatch("hit_gateway", x.hit_gateway, a.hit_gateway);
				if (a.hit_iface !== x.hit_iface)
					mismatch("hit_iface", 32'(x.hit_iface), 32'(a.hit_iface));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	rpl_pkg::req_t req;
	logic busy;
	logic done;
	rpl_pkg::rsp_t rsp;

	lpm_scoreboard board = new();
	int cycles = 0;

	// recently inserted prefixes, used to aim lookups at live routes and to reuse nets in inserts
	logic [31:0] pool_net[rpl_pkg::TABLE_DEPTH];
	logic [31:0] pool_mask[rpl_pkg::TABLE_DEPTH];
	int pool_n = 0;
	int pool_wr = 0;

	ipv4_route_prefix_lookup dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				board.note_request(req);
			if (done)
				board.check_reply(rsp);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic rpl_pkg::req_t mk(logic [1:0] mode, logic [31:0] net,
		logic [31:0] mask, logic [31:0] gw, logic [7:0] iface, logic [31:0] addr);
		rpl_pkg::req_t r;
		r.mode = mode;
		r.route_net = net;
		r.route_mask = mask;
		r.route_gateway = gw;
		r.route_iface = iface;
		r.lookup_addr = addr;
		return r;
	endfunction

	function automatic logic [31:0] prefix_mask(int len);
		logic [31:0] m;
		m = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
		return m;
	endfunction

	function automatic rpl_pkg::req_t random_item();
		rpl_pkg::req_t r;
		int sel;
		int pick;
		r = mk(rpl_pkg::MODE_LOOKUP, $urandom, $urandom, $urandom,
			8'($urandom_range(0, 255)), $urandom);
		sel = $urandom_range(0, 99);
		if (sel < 4) begin
			r.mode = rpl_pkg::MODE_CLEAR;
		end else if (sel < 6) begin
			r.mode = MODE_NOP;
		end else if (sel < 48) begin
			r.mode = rpl_pkg::MODE_INSERT;
			sel = $urandom_range(0, 99);
			if (sel < 15 && pool_n > 0) begin
				pick = $urandom_range(0, pool_n - 1);
				r.route_net = pool_net[pick];
				r.route_mask = ($urandom_range(0, 1) == 1) ? pool_mask[pick] :
					prefix_mask($urandom_range(0, 32));
			end else if (sel < 85) begin
				r.route_mask = prefix_mask($urandom_range(0, 32));
				r.route_net = r.route_net & r.route_mask;
			end
			pool_net[pool_wr] = r.route_net;
			pool_mask[pool_wr] = r.route_mask;
			pool_wr = (pool_wr + 1) % rpl_pkg::TABLE_DEPTH;
			if (pool_n < rpl_pkg::TABLE_DEPTH)
				pool_n++;
		end else if (pool_n > 0 && $urandom_range(0, 99) < 85) begin
			pick = $urandom_range(0, pool_n - 1);
			r.lookup_addr = pool_net[pick] | ($urandom & ~pool_mask[pick]);
		end
		return r;
	endfunction

	task automatic send(rpl_pkg::req_t r);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (board.pending_replies.size() != 0);
	endtask

	task automatic issue(rpl_pkg::req_t r, bit steady);
		if (!steady && $urandom_range(0, 99) < 8)
			pause($urandom_range(1, 4));
		send(r);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(mk(rpl_pkg::MODE_LOOKUP, 0, 0, 0, 0, 32'h0), 0);
		issue(mk(rpl_pkg::MODE_INSERT, 32'h0, 32'h0, 32'hC0A8_0001, 8'd1, 0), 0);
		issue(mk(rpl_pkg::MODE_INSERT, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE,
			8'd2, 0), 0);
		issue(mk(rpl_pkg::MODE_INSERT, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FE,
			8'd3, 0), 0);
		issue(mk(rpl_pkg::MODE_INSERT, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FD,
			8'd4, 0), 0);
		// net has bits outside its mask: stored, never matches
		issue(mk(rpl_pkg::MODE_INSERT, 32'hC0A8_0101, 32'hFFFF_FF00, 32'h5555_5555,
			8'd5, 0), 0);
		issue(mk(rpl_pkg::MODE_INSERT, '1, '1, '1, 8'hFF, 0), 0);
		issue(mk(rpl_pkg::MODE_LOOKUP, 0, 0, 0, 0, 32'h0A01_0203), 0);
		issue(mk(rpl_pkg::MODE_LOOKUP, 0, 0, 0, 0, 32'h0A02_0304), 0);
		issue(mk(rpl_pkg::MODE_LOOKUP, 0, 0, 0, 0, 32'hC0A8_0105), 0);
		issue(mk(rpl_pkg::MODE_LOOKUP, '1, '1, '1, 8'hFF, 32'hFFFF_FFFF), 0);
		issue(mk(rpl_pkg::MODE_LOOKUP, 0, 0, 0, 0, 32'h0), 0);
		issue(mk(MODE_NOP, '1, '1, '1, 8'hFF, '1), 0);
		for (int k = 0; k < rpl_pkg::TABLE_DEPTH - 6; k++)
			issue(mk(rpl_pkg::MODE_INSERT, 32'hAC10_0000 | (k << 8), 32'hFFFF_FF00,
				32'hAC10_0001 + k, 8'(k + 16), 0), 0);
		issue(mk(rpl_pkg::MODE_INSERT, 32'hAC10_0000, 32'hFFFF_0000, 32'h1, 8'd9, 0), 0);
		issue(mk(rpl_pkg::MODE_LOOKUP, 0, 0, 0, 0, 32'hAC10_0301), 0);
		issue(mk(rpl_pkg::MODE_CLEAR, '1, '1, '1, 8'hFF, '1), 0);
		issue(mk(rpl_pkg::MODE_LOOKUP, 0, 0, 0, 0, 32'hFFFF_FFFF), 0);
		drain();

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == RANDOM_ITEMS / 2)
				drain();
			issue(random_item(), k >= 500 && k < 800);
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending_replies.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/rpl_pkg.sv
hw/rtl/rpl_table_mem.sv
hw/rtl/ipv4_route_prefix_lookup.sv
hw/rtl/rpl_checker.sv
verif/ipv4_route_prefix_lookup_test.sv
